@@ rtl/fair_schedule_filter_macros.svh @@
// assertion helpers for the fair schedule filter top module
`ifndef FAIR_SCHEDULE_FILTER_MACROS_SVH
`define FAIR_SCHEDULE_FILTER_MACROS_SVH

// condition holds at every clock edge outside reset
`define FSF_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fsf_pkg.sv @@
package fsf_pkg;

  // fixed field widths of the stream items
  localparam int unsigned EnMaskW   = 16;
  localparam int unsigned LastW     = 4;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 16;

  // default thread count
  localparam int unsigned DefNumThreads = 16;

  // control for one pass of the row update unit
  typedef struct packed {
    logic is_last;  // row belongs to the thread that ran last
    logic yielded;  // that thread ended with a yield
    logic gain;     // this row's thread gains priority over the last thread
  } row_ctl_t;

endpackage

@@ rtl/fsf_row_mem.sv @@
module fsf_row_mem import fsf_pkg::*; #(
  parameter int unsigned NUM_THREADS = DefNumThreads
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [$clog2(NUM_THREADS)-1:0]       rd_addr_i,
  output logic [4*NUM_THREADS-1:0]             rd_row_o,   // {sched, dis, en, prio}
  input  logic                                 wr_en_i,
  input  logic [$clog2(NUM_THREADS)-1:0]       wr_addr_i,
  input  logic [4*NUM_THREADS-1:0]             wr_row_i    // {sched, dis, en, prio}
);

  localparam int unsigned RowW = 4 * NUM_THREADS;

  logic [RowW-1:0]        mem_q [NUM_THREADS];
  logic [RowW-1:0]        rd_q;
  logic [NUM_THREADS-1:0] row_vld_q;
  logic                   rd_vld_q;

  // row storage, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // per-row valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/fsf_row_alu.sv @@
module fsf_row_alu import fsf_pkg::*; #(
  parameter int unsigned NUM_THREADS = DefNumThreads
) (
  input  row_ctl_t                 ctl_i,
  input  logic [NUM_THREADS-1:0]   en_mask_i,
  input  logic [NUM_THREADS-1:0]   prev_mask_i,
  input  logic [NUM_THREADS-1:0]   last_bit_i,
  input  logic [4*NUM_THREADS-1:0] row_i,    // {sched, dis, en, prio}
  output logic [4*NUM_THREADS-1:0] row_o,    // {sched, dis, en, prio}
  output logic [NUM_THREADS-1:0]   hold_o    // threads that gain priority on a yield
);

  localparam int unsigned N = NUM_THREADS;

  logic [N-1:0] prio, en, dis, sched;
  logic [N-1:0] en_m, dis_m, sched_m;
  logic [N-1:0] prio_n, en_n, dis_n, sched_n;
  logic         yreset;

  assign {sched, dis, en, prio} = row_i;

  // update common to every row; the disabled set grows only on the last thread's row
  assign en_m    = en & en_mask_i;
  assign sched_m = sched | last_bit_i;
  assign dis_m   = ctl_i.is_last ? (dis | (prev_mask_i & ~en_mask_i)) : dis;

  // holders over the last thread, from its own updated row
  assign hold_o  = (en_m | dis_m) & ~sched_m;

  // yield resets the last thread's rows; its prio row clears on every item
  assign yreset  = ctl_i.is_last & ctl_i.yielded;
  assign prio_n  = ctl_i.is_last ? '0 : (ctl_i.gain ? (prio | last_bit_i) : prio);
  assign en_n    = yreset ? en_mask_i : en_m;
  assign dis_n   = yreset ? '0 : dis_m;
  assign sched_n = yreset ? '0 : sched_m;

  assign row_o = {sched_n, dis_n, en_n, prio_n};

endmodule

@@ rtl/fair_schedule_filter.sv @@
// Fairness filter for a model-checking scheduler. Each input item carries the
// enabled-thread mask, the thread that ran last and its yield flag. The block
// updates its per-thread priority, enabled, disabled and scheduled rows and
// returns one item: the enabled threads that no enabled thread has priority
// over. A new item is accepted only after the previous one has been swept
// and handed to the output register. The accepting cycle also fetches the last
// thread's row. The next cycle works out which threads gain priority over it.
// Then the sweep passes every row in turn through the single row update unit
// and row memory port, and a finish state hands the result to the output
// register. The input is not ready from acceptance until that hand-over; it is
// ready again while a result still waits to be taken. A stalled output holds
// the finish state only when the previous result is still waiting at the end
// of the sweep. No clearing pass is needed after reset: per-row valid bits make
// rows that were never written read as zero.
module fair_schedule_filter import fsf_pkg::*; #(
  parameter int unsigned NUM_THREADS = DefNumThreads
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [InDataW-1:0]  s_tdata_i,   // enabled_mask, last_thread, last_yielded
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o    // fair_mask
);

`include "fair_schedule_filter_macros.svh"

  localparam int unsigned N      = NUM_THREADS;
  localparam int unsigned IdxW   = $clog2(N);
  localparam int unsigned WideW  = (N > EnMaskW) ? N : EnMaskW;
  localparam int unsigned LWideW = (IdxW > LastW) ? IdxW : LastW;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StLook   = 2'd1;
  localparam logic [1:0] StSweep  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [IdxW-1:0]     cnt_q, cnt_d;
  logic [N-1:0]        e_q, prev_q, lbit_q, hold_q, blk_q;
  logic [IdxW-1:0]     idx_q;
  logic                vld_q, yld_q;
  logic                m_vld_q;
  logic [OutDataW-1:0] m_data_q;

  logic [EnMaskW-1:0]  in_en;
  logic [LastW-1:0]    in_last;
  logic                in_yld;
  logic [WideW-1:0]    in_en_wide;
  logic [LWideW-1:0]   in_last_wide;
  logic [N-1:0]        in_e;
  logic [IdxW-1:0]     in_idx;
  logic                in_vld;
  logic                s_acc;
  logic                cnt_end;
  logic                out_load;
  logic [WideW-1:0]    fair_wide;

  logic                rd_en, wr_en;
  logic [IdxW-1:0]     rd_addr;
  logic [4*N-1:0]      rd_row, wr_row;
  logic [N-1:0]        alu_hold;
  row_ctl_t            ctl;

  // input unpacking, widened or trimmed to the thread count
  assign {in_yld, in_last, in_en} = s_tdata_i[EnMaskW+LastW:0];
  assign in_en_wide   = WideW'(in_en);
  assign in_e         = in_en_wide[N-1:0];
  assign in_last_wide = LWideW'(in_last);
  assign in_idx       = in_last_wide[IdxW-1:0];
  assign in_vld       = 32'(in_last) < N;

  assign s_tready_o = (state_q == StIdle);
  assign s_acc      = s_tvalid_i & s_tready_o;
  assign cnt_end    = (cnt_q == IdxW'(N - 1));
  assign out_load   = (state_q == StFinish) & (~m_vld_q | m_tready_i);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_idx;
    unique case (state_q)
      StIdle: begin
        rd_en = s_acc;
      end
      StLook: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      StSweep: begin
        rd_en   = ~cnt_end;
        rd_addr = cnt_q + IdxW'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en = (state_q == StSweep);

  // row update unit control
  always_comb begin
    ctl.yielded = yld_q;
    ctl.gain    = hold_q[cnt_q];
    ctl.is_last = vld_q & ((state_q == StLook) | (cnt_q == idx_q));
  end

  fsf_row_mem #(
    .NUM_THREADS(NUM_THREADS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_row_o (rd_row),
    .wr_en_i  (wr_en),
    .wr_addr_i(cnt_q),
    .wr_row_i (wr_row)
  );

  fsf_row_alu #(
    .NUM_THREADS(NUM_THREADS)
  ) u_alu (
    .ctl_i      (ctl),
    .en_mask_i  (e_q),
    .prev_mask_i(prev_q),
    .last_bit_i (lbit_q),
    .row_i      (rd_row),
    .row_o      (wr_row),
    .hold_o     (alu_hold)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (s_acc) state_d = StLook;
      end
      StLook: begin
        cnt_d   = '0;
        state_d = StSweep;
      end
      StSweep: begin
        cnt_d = cnt_q + IdxW'(1);
        if (cnt_end) state_d = StFinish;
      end
      StFinish: begin
        if (out_load) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      prev_q  <= '0;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        prev_q  <= e_q;
        m_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // item payload, holders, blocked set and output data
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      e_q    <= in_e;
      idx_q  <= in_idx;
      vld_q  <= in_vld;
      yld_q  <= in_yld;
      lbit_q <= in_vld ? (N'(1) << in_idx) : '0;
      blk_q  <= '0;
    end
    if (state_q == StLook) begin
      hold_q <= (vld_q & yld_q) ? alu_hold : '0;
    end
    if (state_q == StSweep && e_q[cnt_q]) begin
      blk_q <= blk_q | wr_row[N-1:0];
    end
    if (out_load) begin
      m_data_q <= fair_wide[OutDataW-1:0];
    end
  end

  assign fair_wide  = WideW'(e_q & ~blk_q);
  assign m_tvalid_o = m_vld_q;
  assign m_tdata_o  = m_data_q;

  // checks
  `FSF_ASSERT_HOLD(a_wr_only_sweep, !wr_en || state_q == StSweep, "row write outside sweep")
  `FSF_ASSERT_NEXT(a_look_to_sweep, state_q == StLook,
                   state_q == StSweep && cnt_q == '0, "sweep did not start at row zero")
  `FSF_ASSERT_NEXT(a_sweep_step, state_q == StSweep && !cnt_end,
                   state_q == StSweep && cnt_q == IdxW'($past(cnt_q) + IdxW'(1)),
                   "sweep skipped a row")
  `FSF_ASSERT_NEXT(a_load_valid, out_load, m_vld_q && state_q == StIdle, "result not presented")

endmodule

@@ test/fair_schedule_filter_tb.sv @@
module fair_schedule_filter_tb;
  import fsf_pkg::*;

  localparam int unsigned NThr = DefNumThreads;

  // input item layout, lowest bits first: enabled mask, last thread, yield flag
  typedef struct packed {
    logic [InDataW-EnMaskW-LastW-2:0] pad;
    logic                             yielded;
    logic [LastW-1:0]                 last;
    logic [EnMaskW-1:0]               en;
  } sched_item_t;

  // one directed row; known marks a fair mask typed in by hand
  typedef struct packed {
    logic [EnMaskW-1:0]  en;
    logic [LastW-1:0]    last;
    logic                yielded;
    logic                known;
    logic [OutDataW-1:0] fair;
  } dir_row_t;

  localparam int NumDirected = 20;
  localparam int RandPerPhase = 375;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [InDataW-1:0]  s_tdata_i = '0;
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [OutDataW-1:0] m_tdata_o;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int          errors = 0;

  // shadow copy of the scheduler matrices
  logic [NThr-1:0] prio_row  [NThr];
  logic [NThr-1:0] en_row    [NThr];
  logic [NThr-1:0] dis_row   [NThr];
  logic [NThr-1:0] sched_row [NThr];
  logic [NThr-1:0] prev_en;

  logic [OutDataW-1:0] pending_fair [$];

  // directed stimulus: extremes, empty and full masks, yields by edge threads
  dir_row_t directed_rows [NumDirected] = '{
    {16'hFFFF, 4'd0,  1'b0, 1'b1, 16'hFFFF},
    {16'hFFFF, 4'd15, 1'b0, 1'b0, 16'h0000},
    {16'h0000, 4'd0,  1'b1, 1'b1, 16'h0000},
    {16'hFFFF, 4'd0,  1'b1, 1'b0, 16'h0000},
    {16'h0003, 4'd0,  1'b0, 1'b0, 16'h0000},
    {16'h0003, 4'd1,  1'b1, 1'b0, 16'h0000},
    {16'h0003, 4'd0,  1'b1, 1'b0, 16'h0000},
    {16'h0001, 4'd0,  1'b1, 1'b0, 16'h0000},
    {16'h0003, 4'd1,  1'b0, 1'b0, 16'h0000},
    {16'h0003, 4'd0,  1'b1, 1'b0, 16'h0000},
    {16'h8000, 4'd15, 1'b1, 1'b0, 16'h0000},
    {16'hAAAA, 4'd1,  1'b1, 1'b0, 16'h0000},
    {16'h5555, 4'd0,  1'b1, 1'b0, 16'h0000},
    {16'hFFFF, 4'd15, 1'b1, 1'b0, 16'h0000},
    {16'hFFFF, 4'd7,  1'b1, 1'b0, 16'h0000},
    {16'h0000, 4'd15, 1'b0, 1'b1, 16'h0000},
    {16'hFFFF, 4'd8,  1'b1, 1'b0, 16'h0000},
    {16'h00FF, 4'd3,  1'b1, 1'b0, 16'h0000},
    {16'hFF00, 4'd12, 1'b1, 1'b0, 16'h0000},
    {16'hFFFF, 4'd15, 1'b1, 1'b0, 16'h0000}
  };

  fair_schedule_filter #(
    .NUM_THREADS(NThr)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one scheduling step on the shadow matrices, returns the fair mask
  function automatic logic [OutDataW-1:0] fair_step(input logic [NThr-1:0] e,
                                                    input logic [LastW-1:0] l,
                                                    input logic y);
    logic [NThr-1:0] lbit;
    logic [NThr-1:0] gainers;
    logic [NThr-1:0] blocked;
    lbit = '0;
    lbit[l] = 1'b1;
    blocked = '0;
    prio_row[l] = '0;
    for (int t = 0; t < NThr; t++) begin
      en_row[t] &= e;
      sched_row[t] |= lbit;
    end
    dis_row[l] |= prev_en & ~e;
    // a yield hands priority to threads the yielder enabled-through or disabled
    if (y) begin
      gainers = (en_row[l] | dis_row[l]) & ~sched_row[l];
      for (int t = 0; t < NThr; t++) begin
        if (gainers[t]) prio_row[t] |= lbit;
      end
      en_row[l] = e;
      dis_row[l] = '0;
      sched_row[l] = '0;
    end
    for (int t = 0; t < NThr; t++) begin
      if (e[t]) blocked |= prio_row[t];
    end
    prev_en = e;
    return e & ~blocked;
  endfunction

  // present one item, with random gaps ahead of it, until it is taken
  task automatic push_item(input sched_item_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= item;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  // result side back-pressure
  always @(negedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // compare each taken item with the oldest expected fair mask
  always @(posedge clk_i) begin : take_result
    logic [OutDataW-1:0] want_fair;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_fair.size() == 0) begin
        $display("%0t: unexpected fair mask, expected none, got %h", $time, m_tdata_o);
        errors++;
      end else begin
        want_fair = pending_fair.pop_front();
        if (m_tdata_o !== want_fair) begin
          $display("%0t: fair mask mismatch, expected %h, got %h",
                   $time, want_fair, m_tdata_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    sched_item_t         item;
    dir_row_t            row;
    logic [OutDataW-1:0] fair_now;
    logic [OutDataW-1:0] fair_prev;
    for (int t = 0; t < NThr; t++) begin
      prio_row[t] = '0;
      en_row[t] = '0;
      dis_row[t] = '0;
      sched_row[t] = '0;
    end
    prev_en = '0;
    fair_prev = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    for (int i = 0; i < NumDirected; i++) begin
      row = directed_rows[i];
      item = '0;
      item.en = row.en;
      item.last = row.last;
      item.yielded = row.yielded;
      push_item(item);
      fair_now = fair_step(row.en, row.last, row.yielded);
      pending_fair = {pending_fair, (row.known ? row.fair : fair_now)};
      fair_prev = fair_now;
    end

    // random runs under four flow-control settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 86;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 86;
        end
        default: begin
          src_idle_pct = 37;
          sink_stall_pct = 37;
        end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        item = '0;
        if ($urandom_range(99) < 80) begin
          // plausible run: mask drifts a little, next thread from the fair set
          item.en = prev_en;
          repeat ($urandom_range(2)) item.en ^= 16'(1) << $urandom_range(15);
          if ($urandom_range(9) == 0) item.en = EnMaskW'($urandom);
          item.last = LastW'($urandom_range(NThr - 1));
          if (fair_prev != '0) begin
            while (!fair_prev[item.last]) item.last++;
          end
          item.yielded = ($urandom_range(2) == 0);
        end else begin
          item.en = EnMaskW'($urandom);
          item.last = LastW'($urandom_range(NThr - 1));
          item.yielded = 1'($urandom_range(1));
        end
        push_item(item);
        fair_now = fair_step(item.en, item.last, item.yielded);
        pending_fair = {pending_fair, fair_now};
        fair_prev = fair_now;
      end
    end
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    sink_stall_pct = 0;

    // drain, then watch a while for stray items
    while (pending_fair.size() != 0) @(posedge clk_i);
    repeat (2 * (NThr + 3) + 10) @(posedge clk_i);
    if (pending_fair.size() != 0) begin
      $display("%0t: %0d fair masks never arrived", $time, pending_fair.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
